>>> rtl/tsps_pkg.sv
// shared constants and types of the transport stream packet synchronizer
`timescale 1ns / 1ps
package tsps_pkg;

   localparam int PACKET_BYTES = 188;
   localparam int PTR_W        = $clog2(PACKET_BYTES);
   localparam int LEFT_W       = PTR_W;

   localparam logic [PTR_W-1:0]  LAST_POS   = PTR_W'(PACKET_BYTES - 1);
   localparam logic [LEFT_W-1:0] BODY_LEFT  = LEFT_W'(PACKET_BYTES - 1);
   localparam logic [7:0]        SYNC_RESET = 8'h47;

   typedef struct packed {
      logic [7:0] old_byte;
      logic [7:0] new_byte;
      logic       full;
   } tap_type;

endpackage

>>> rtl/tsps_if.sv
// beat channels of the packet synchronizer
`timescale 1ns / 1ps
interface tsps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface tsps_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       first_of_packet;
   logic       last_of_packet;

   modport source (output valid, output packet_byte, output first_of_packet,
                   output last_of_packet, input ready);
   modport sink (input valid, input packet_byte, input first_of_packet,
                 input last_of_packet, output ready);
endinterface

>>> rtl/tsps_delay_line.sv
// packet-length delay line held in a read-first synchronous memory
`timescale 1ns / 1ps
module tsps_delay_line (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [7:0]       push_byte,
   output tsps_pkg::tap_type tap_ff
);

   logic [7:0] mem [tsps_pkg::PACKET_BYTES];

   logic [tsps_pkg::PTR_W-1:0] wp_ff;
   logic [tsps_pkg::PTR_W-1:0] wp_in;
   logic                       full_ff;
   logic                       full_in;
   logic                       wrap;

   assign wrap  = (wp_ff == tsps_pkg::LAST_POS);
   assign wp_in = push ? (wrap ? '0 : wp_ff + 1'b1) : wp_ff;
   assign full_in = full_ff | (push & wrap);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wp_ff]      <= push_byte;
         tap_ff.old_byte <= mem[wp_ff];
         tap_ff.new_byte <= push_byte;
         tap_ff.full     <= full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         full_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         full_ff <= full_in;
      end
   end

endmodule

>>> rtl/ts_packet_synchronizer.sv
// transport stream packet synchronizer top level
// path: the delay line tap registers each accepted byte, then the output beat register holds the result
// throughput: one byte per cycle while the output is not stalled, set by the single read-first delay line port
// read and write of the same entry share one cycle
// reset: control state clears, sync value returns to 0x47, boundary expected
// delay line contents are not cleared; nothing is emitted for the first packet length of bytes
`timescale 1ns / 1ps
module ts_packet_synchronizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   tsps_req_if.sink    req_if,
   tsps_rsp_if.source  rsp_if
);

   tsps_pkg::tap_type tap_ff;

   logic [7:0]                  sync_ff;
   logic [7:0]                  sync_in;
   logic                        s1_vld_ff;
   logic                        s1_vld_in;
   logic [tsps_pkg::LEFT_W-1:0] left_ff;
   logic [tsps_pkg::LEFT_W-1:0] left_in;
   logic                        expect_ff;
   logic                        expect_in;
   logic                        out_vld_ff;
   logic                        out_vld_in;
   logic [7:0]                  out_byte_ff;
   logic                        out_first_ff;
   logic                        out_last_ff;

   logic req_fire;
   logic rsp_fire;
   logic out_free;
   logic s1_go;
   logic s1_fire;
   logic s1_emit;
   logic s1_first;
   logic s1_last;
   logic old_sync;
   logic new_sync;

   tsps_delay_line u_delay_line (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_byte (req_if.stream_byte),
      .tap_ff    (tap_ff)
   );

   assign old_sync = (tap_ff.old_byte == sync_ff);
   assign new_sync = (tap_ff.new_byte == sync_ff);

   // packet decision on the byte leaving the delay line
   always_comb begin
      s1_emit   = 1'b0;
      s1_first  = 1'b0;
      s1_last   = 1'b0;
      left_in   = left_ff;
      expect_in = expect_ff;
      if (tap_ff.full) begin
         if (left_ff != '0) begin
            s1_emit = 1'b1;
            s1_last = (left_ff == tsps_pkg::LEFT_W'(1));
            left_in = left_ff - 1'b1;
            if (s1_last) begin
               expect_in = 1'b1;
            end
         end else if (expect_ff && old_sync) begin
            s1_emit  = 1'b1;
            s1_first = 1'b1;
            left_in  = tsps_pkg::BODY_LEFT;
         end else begin
            expect_in = 1'b0;
            if (old_sync && new_sync) begin
               s1_emit  = 1'b1;
               s1_first = 1'b1;
               left_in  = tsps_pkg::BODY_LEFT;
            end
         end
      end
   end

   assign out_free = !out_vld_ff || rsp_if.ready;
   assign s1_go    = !s1_emit || out_free;
   assign s1_fire  = s1_vld_ff && s1_go;
   assign req_if.ready = !s1_vld_ff || s1_go;
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = out_vld_ff && rsp_if.ready;

   assign s1_vld_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_ff);
   assign out_vld_in = (s1_fire && s1_emit) ? 1'b1 : (rsp_fire ? 1'b0 : out_vld_ff);
   assign sync_in    = csr_we ? csr_wdata : sync_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff    <= tsps_pkg::SYNC_RESET;
         s1_vld_ff  <= 1'b0;
         left_ff    <= '0;
         expect_ff  <= 1'b1;
         out_vld_ff <= 1'b0;
      end else begin
         sync_ff    <= sync_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
         if (s1_fire) begin
            left_ff   <= left_in;
            expect_ff <= expect_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_emit) begin
         out_byte_ff  <= tap_ff.old_byte;
         out_first_ff <= s1_first;
         out_last_ff  <= s1_last;
      end
   end

   assign rsp_if.valid           = out_vld_ff;
   assign rsp_if.packet_byte     = out_byte_ff;
   assign rsp_if.first_of_packet = out_first_ff;
   assign rsp_if.last_of_packet  = out_last_ff;

   a_first_last_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.first_of_packet && rsp_if.last_of_packet))
      else $error("beat marked both first and last of packet");

   a_boundary_after_last: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_emit && s1_last |=> expect_ff && (left_ff == '0))
      else $error("packet end did not rearm boundary");

   a_quiet_while_filling: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !tap_ff.full |-> !s1_emit)
      else $error("beat emitted before delay line full");

   a_first_only_between_packets: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s1_emit && s1_first |-> (left_ff == '0) && old_sync)
      else $error("packet start inside a packet");

endmodule
